/* design/skv_pkg.sv */
// skv_pkg: shared types and constants for the sorted key/value table
// used by the interfaces, controller, datapath and top level
`default_nettype none

package skv_pkg;

    localparam int KEY_W = 64;
    localparam int VAL_W = 64;
    localparam int CAP_W = 7;
    localparam int CNT_W = 7;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_TYPE     = 3'd1,
        ST_CONFLICT = 3'd2,
        ST_FULL     = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    typedef struct packed {
        logic    load;
        logic    idx_clr;
        logic    idx_inc;
        logic    idx_dec;
        logic    idx_top;
        logic    pos_save;
        logic    wr_shift;
        logic    wr_new;
        logic    fill_inc;
        logic    res_load;
        logic    found_sel;
        t_status status;
    } t_cmd;

    typedef struct packed {
        logic kind;
        logic key_ok;
        logic val_ok;
        logic lt_n;
        logic key_eq;
        logic key_gt;
        logic val_eq;
        logic full;
        logic at_pos;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

/* design/skv_if.sv */
// skv_if: handshake channels of the sorted key/value table
// item input, result output and capacity write; depends on skv_pkg
`default_nettype none

interface skv_item_if import skv_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             kind;
    logic [KEY_W-1:0] key;
    logic             key_tag_ok;
    logic [VAL_W-1:0] value;
    logic             value_tag_ok;

    modport source (output valid, kind, key, key_tag_ok, value, value_tag_ok, input ready);
    modport sink   (input valid, kind, key, key_tag_ok, value, value_tag_ok, output ready);
endinterface

interface skv_res_if import skv_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [2:0]       status;
    logic [VAL_W-1:0] found_value;
    logic [CNT_W-1:0] entry_count;

    modport source (output valid, status, found_value, entry_count, input ready);
    modport sink   (input valid, status, found_value, entry_count, output ready);
endinterface

interface skv_cfg_if import skv_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

/* design/sorted_key_value_table_top.sv */
// sorted_key_value_table_top: sorted key/value table with insert and lookup
// joins skv_ctrl and skv_dp to the channels of skv_if; depends on skv_pkg
//
//  channel  dir  handshake     payload
//  i_item   in   valid/ready   kind, key, key_tag_ok, value, value_tag_ok
//  o_res    out  valid/ready   status, found_value, entry_count
//  i_cfg    in   valid/ready   data (capacity_limit), ready always high
//
// one item at a time; the pair memory has one read and one write port
// lookup: an accept step, then a walk from entry 0 that ends at a match, a larger key or the end of the n entries held
// insert: an accept step, a walk to slot p, a shift of entries n-1 down to p up by one, then a place step
// synchronous active-low reset empties the table and sets capacity to 64
// a stalled result holds the controller at its final step
`default_nettype none

module sorted_key_value_table_top import skv_pkg::*; #(
    parameter int DEPTH      = 64,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    skv_item_if.sink   i_item,
    skv_res_if.source  o_res,
    skv_cfg_if.sink    i_cfg
);

    t_cmd w_cmd;
    t_sts w_sts;

    assign i_cfg.ready = 1'b1;

    skv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (i_item.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    skv_dp #(
        .DEPTH      (DEPTH),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_kind        (i_item.kind),
        .i_key         (i_item.key),
        .i_key_ok      (i_item.key_tag_ok),
        .i_value       (i_item.value),
        .i_value_ok    (i_item.value_tag_ok),
        .i_cfg_we      (i_cfg.valid),
        .i_cfg_data    (i_cfg.data),
        .i_out_ready   (o_res.ready),
        .o_out_valid   (o_res.valid),
        .o_status      (o_res.status),
        .o_found_value (o_res.found_value),
        .o_entry_count (o_res.entry_count)
    );

    a_res_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.res_load |-> w_sts.out_free)
        else $error("result loaded over a pending result");

    a_shift_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.wr_shift || w_cmd.fill_inc) |-> !w_sts.full)
        else $error("table grows past its capacity");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> !i_item.ready)
        else $error("second item taken while one is at work");

    a_place_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.wr_new |-> (w_cmd.res_load && w_cmd.status == ST_OK))
        else $error("pair placed without an ok result");

endmodule

`default_nettype wire

/* design/skv_ctrl.sv */
// skv_ctrl: controller state machine of the sorted key/value table
// drives datapath commands from datapath status; depends on skv_pkg
`default_nettype none

module skv_ctrl import skv_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SRCH,
        S_SHIFT,
        S_PLACE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   type_bad;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        if (i_sts.kind == KIND_INSERT) begin
            type_bad = !(i_sts.key_ok && i_sts.val_ok);
        end else begin
            type_bad = !i_sts.key_ok;
        end
    end

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load    = 1'b1;
                    o_cmd.idx_clr = 1'b1;
                    n_state       = S_SRCH;
                end
            end
            S_SRCH: begin
                priority if (type_bad) begin
                    if (i_sts.out_free) begin
                        o_cmd.res_load = 1'b1;
                        o_cmd.status   = ST_TYPE;
                        n_state        = S_IDLE;
                    end
                end else if (i_sts.kind == KIND_LOOKUP) begin
                    priority if (!i_sts.lt_n || i_sts.key_gt) begin
                        if (i_sts.out_free) begin
                            o_cmd.res_load = 1'b1;
                            o_cmd.status   = ST_NOTFOUND;
                            n_state        = S_IDLE;
                        end
                    end else if (i_sts.key_eq) begin
                        if (i_sts.out_free) begin
                            o_cmd.res_load  = 1'b1;
                            o_cmd.found_sel = 1'b1;
                            o_cmd.status    = ST_OK;
                            n_state         = S_IDLE;
                        end
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                    end
                end else begin
                    priority if (i_sts.lt_n && !i_sts.key_eq && !i_sts.key_gt) begin
                        o_cmd.idx_inc = 1'b1;
                    end else if (i_sts.lt_n && i_sts.key_eq) begin
                        if (i_sts.out_free) begin
                            o_cmd.res_load = 1'b1;
                            o_cmd.status   = i_sts.val_eq ? ST_OK : ST_CONFLICT;
                            n_state        = S_IDLE;
                        end
                    end else if (i_sts.full) begin
                        if (i_sts.out_free) begin
                            o_cmd.res_load = 1'b1;
                            o_cmd.status   = ST_FULL;
                            n_state        = S_IDLE;
                        end
                    end else if (!i_sts.lt_n) begin
                        o_cmd.pos_save = 1'b1;
                        n_state        = S_PLACE;
                    end else begin
                        o_cmd.pos_save = 1'b1;
                        o_cmd.idx_top  = 1'b1;
                        n_state        = S_SHIFT;
                    end
                end
            end
            S_SHIFT: begin
                o_cmd.wr_shift = 1'b1;
                if (i_sts.at_pos) begin
                    n_state = S_PLACE;
                end else begin
                    o_cmd.idx_dec = 1'b1;
                end
            end
            S_PLACE: begin
                if (i_sts.out_free) begin
                    o_cmd.wr_new   = 1'b1;
                    o_cmd.fill_inc = 1'b1;
                    o_cmd.res_load = 1'b1;
                    o_cmd.status   = ST_OK;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

/* design/skv_dp.sv */
// skv_dp: datapath of the sorted key/value table
// pair memory, walk index, fill count, capacity and result register; depends on skv_pkg
`default_nettype none

module skv_dp import skv_pkg::*; #(
    parameter int DEPTH      = 64,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    input  logic             i_kind,
    input  logic [KEY_W-1:0] i_key,
    input  logic             i_key_ok,
    input  logic [VAL_W-1:0] i_value,
    input  logic             i_value_ok,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_data,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic [2:0]       o_status,
    output logic [VAL_W-1:0] o_found_value,
    output logic [CNT_W-1:0] o_entry_count
);

    localparam int CW  = $clog2(DEPTH + 1);
    localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int EW  = KEY_BITS + VALUE_BITS;
    localparam int CXW = (CW > CAP_W) ? CW : CAP_W;

    logic [EW-1:0]         mem [DEPTH];
    logic [EW-1:0]         r_rd_data;
    logic                  r_kind;
    logic [KEY_BITS-1:0]   r_key;
    logic                  r_key_ok;
    logic [VALUE_BITS-1:0] r_val;
    logic                  r_val_ok;
    logic [CW-1:0]         r_idx;
    logic [CW-1:0]         n_idx;
    logic [CW-1:0]         r_pos;
    logic [CW-1:0]         r_fill;
    logic [CAP_W-1:0]      r_cap;
    logic                  r_out_valid;
    logic [2:0]            r_status;
    logic [VAL_W-1:0]      r_found;
    logic [CNT_W-1:0]      r_count;
    logic [CW-1:0]         wr_addr;
    logic [CW-1:0]         fill_next;
    logic [KEY_BITS-1:0]   rd_key;
    logic [VALUE_BITS-1:0] rd_val;

    assign rd_key    = r_rd_data[EW-1:VALUE_BITS];
    assign rd_val    = r_rd_data[VALUE_BITS-1:0];
    assign fill_next = i_cmd.fill_inc ? (r_fill + 1'b1) : r_fill;
    assign wr_addr   = i_cmd.wr_new ? r_pos : (r_idx + 1'b1);

    always_comb begin
        priority if (i_cmd.idx_clr) begin
            n_idx = '0;
        end else if (i_cmd.idx_inc) begin
            n_idx = r_idx + 1'b1;
        end else if (i_cmd.idx_dec) begin
            n_idx = r_idx - 1'b1;
        end else if (i_cmd.idx_top) begin
            n_idx = r_fill - 1'b1;
        end else begin
            n_idx = r_idx;
        end
    end

    // read data belongs to the index register while the index is below DEPTH
    always_ff @(posedge i_clk) begin
        if (n_idx < CW'(DEPTH)) begin
            r_rd_data <= mem[n_idx[AW-1:0]];
        end
        if (i_cmd.wr_new) begin
            mem[wr_addr[AW-1:0]] <= {r_key, r_val};
        end else if (i_cmd.wr_shift) begin
            mem[wr_addr[AW-1:0]] <= r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind   <= i_kind;
            r_key    <= i_key[KEY_BITS-1:0];
            r_key_ok <= i_key_ok;
            r_val    <= i_value[VALUE_BITS-1:0];
            r_val_ok <= i_value_ok;
        end
        r_idx <= n_idx;
        if (i_cmd.pos_save) begin
            r_pos <= r_idx;
        end
        if (i_cmd.res_load) begin
            r_status <= i_cmd.status;
            r_found  <= i_cmd.found_sel ? VAL_W'(rd_val) : '0;
            r_count  <= CNT_W'(fill_next);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_cap       <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_fill <= fill_next;
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (i_cmd.res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.kind     = r_kind;
        o_sts.key_ok   = r_key_ok;
        o_sts.val_ok   = r_val_ok;
        o_sts.lt_n     = (r_idx < r_fill);
        o_sts.key_eq   = (rd_key == r_key);
        o_sts.key_gt   = (rd_key > r_key);
        o_sts.val_eq   = (rd_val == r_val);
        o_sts.full     = (r_fill >= CW'(DEPTH)) || (CXW'(r_fill) >= CXW'(r_cap));
        o_sts.at_pos   = (r_idx == r_pos);
        o_sts.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_found_value = r_found;
    assign o_entry_count = r_count;

endmodule

`default_nettype wire

/* bench/tb_sorted_key_value_table_top.sv */
// tb_sorted_key_value_table_top: self-checking bench for the sorted key/value table
// drives the item and capacity channels, predicts every result; depends on skv_pkg, skv_if
`default_nettype none

module tb_sorted_key_value_table_top;
    import skv_pkg::*;

    localparam int DEPTH           = 64;
    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 9;
    localparam int STALL_LIMIT     = 5000;
    localparam int PRESSURE_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 4;
    localparam int TAIL_CYCLES     = 20;
    localparam int REPORT_MAX      = 10;

    typedef struct {
        logic             kind;
        logic [KEY_W-1:0] key;
        logic             key_ok;
        logic [VAL_W-1:0] val;
        logic             val_ok;
    } t_req;

    typedef struct {
        t_status          status;
        logic [VAL_W-1:0] found;
        logic [CNT_W-1:0] count;
    } t_result;

    logic i_clk;
    logic i_rst_n;

    skv_item_if item_ch ();
    skv_res_if  res_ch ();
    skv_cfg_if  cfg_ch ();

    sorted_key_value_table_top #(
        .DEPTH      (DEPTH),
        .KEY_BITS   (KEY_W),
        .VALUE_BITS (VAL_W)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    logic [KEY_W-1:0] table_keys [DEPTH];
    logic [VAL_W-1:0] table_vals [DEPTH];
    int               table_fill;
    int               cap_reg;
    t_result          expected_q [$];
    int               mismatch_count;
    int               quiet_cycles;
    int               send_idle_pct;
    int               recv_idle_pct;
    int               hold_request;
    int               hold_left;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic t_result apply_item(input t_req r);
        t_result o;
        int      n;
        int      at;
        int      lim;
        int      j;
        o.status = ST_OK;
        o.found  = '0;
        n   = table_fill;
        at  = 0;
        lim = (cap_reg > DEPTH) ? DEPTH : cap_reg;
        if (r.kind == KIND_LOOKUP) begin
            if (!r.key_ok) begin
                o.status = ST_TYPE;
            end else begin
                o.status = ST_NOTFOUND;
                while (at < n && table_keys[at] < r.key) at++;
                if (at < n && table_keys[at] == r.key) begin
                    o.status = ST_OK;
                    o.found  = table_vals[at];
                end
            end
        end else if (!r.key_ok || !r.val_ok) begin
            o.status = ST_TYPE;
        end else begin
            while (at < n && table_keys[at] < r.key) at++;
            if (at < n && table_keys[at] == r.key) begin
                o.status = (table_vals[at] == r.val) ? ST_OK : ST_CONFLICT;
            end else if (n >= lim) begin
                o.status = ST_FULL;
            end else begin
                for (j = n; j > at; j--) begin
                    table_keys[j] = table_keys[j-1];
                    table_vals[j] = table_vals[j-1];
                end
                table_keys[at] = r.key;
                table_vals[at] = r.val;
                table_fill = n + 1;
            end
        end
        o.count = table_fill[CNT_W-1:0];
        return o;
    endfunction

    function automatic t_req mk_item(input logic kind, input logic [KEY_W-1:0] key,
                                     input logic key_ok, input logic [VAL_W-1:0] val,
                                     input logic val_ok);
        t_req r;
        r.kind   = kind;
        r.key    = key;
        r.key_ok = key_ok;
        r.val    = val;
        r.val_ok = val_ok;
        return r;
    endfunction

    function automatic t_req random_item();
        t_req r;
        int   pick;
        int   idx;
        r.kind   = KIND_INSERT;
        r.key    = {$urandom, $urandom};
        r.key_ok = 1'b1;
        r.val    = {$urandom, $urandom};
        r.val_ok = 1'b1;
        pick = $urandom_range(99);
        idx  = (table_fill > 0) ? $urandom_range(table_fill - 1) : 0;
        if (pick < 25) begin
            r.kind   = KIND_LOOKUP;
            r.val_ok = 1'($urandom_range(1));
            if (table_fill > 0) r.key = table_keys[idx];
        end else if (pick < 35) begin
            r.kind   = KIND_LOOKUP;
            r.val_ok = 1'($urandom_range(1));
            if (table_fill > 0)
                r.key = $urandom_range(1) ? table_keys[idx] + 64'd1 : table_keys[idx] - 64'd1;
        end else if (pick < 45) begin
            if (table_fill > 0) begin
                r.key = table_keys[idx];
                r.val = table_vals[idx];
            end
        end else if (pick < 52) begin
            if (table_fill > 0) r.key = table_keys[idx];
        end else if (pick < 65) begin
            if (table_fill > 0)
                r.key = $urandom_range(1) ? table_keys[idx] + 64'd1 : table_keys[idx] - 64'd1;
        end else if (pick >= 85) begin
            r.kind   = 1'($urandom_range(1));
            r.key_ok = 1'($urandom_range(1));
            r.val_ok = 1'($urandom_range(1));
        end
        return r;
    endfunction

    // result ready, with a long hold-off on request
    initial begin
        res_ch.ready = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request != 0) begin
                hold_request = 0;
                hold_left = PRESSURE_CYCLES;
            end
            if (hold_left > 0) begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        logic    moved;
        t_result want;
        t_req    seen;
        moved = 1'b0;
        if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                moved = 1'b1;
                if (expected_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("unexpected result: status %0d found %h count %0d",
                                 res_ch.status, res_ch.found_value, res_ch.entry_count);
                end else begin
                    want = expected_q.pop_front();
                    if (res_ch.status !== want.status || res_ch.found_value !== want.found ||
                        res_ch.entry_count !== want.count) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX) begin
                            $display("mismatch: expected status %0d found %h count %0d",
                                     want.status, want.found, want.count);
                            $display("          got status %0d found %h count %0d",
                                     res_ch.status, res_ch.found_value, res_ch.entry_count);
                        end
                    end
                end
            end
            if (item_ch.valid && item_ch.ready) begin
                moved = 1'b1;
                seen = mk_item(item_ch.kind, item_ch.key, item_ch.key_tag_ok,
                               item_ch.value, item_ch.value_tag_ok);
                expected_q.push_back(apply_item(seen));
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                moved = 1'b1;
                cap_reg = int'(cfg_ch.data);
            end
            if (moved) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT) begin
                    $display("status: fail");
                    $finish;
                end
            end
        end
    end

    task automatic send_item(input t_req r);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.kind         <= r.kind;
        item_ch.key          <= r.key;
        item_ch.key_tag_ok   <= r.key_ok;
        item_ch.value        <= r.val;
        item_ch.value_tag_ok <= r.val_ok;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
    endtask

    task automatic settle();
        @(negedge i_clk);
        item_ch.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        settle();
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= cap;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [CAP_W-1:0] cap, input int count);
        write_capacity(cap);
        repeat (count) send_item(random_item());
    endtask

    task automatic test_directed();
        send_idle_pct = 36;
        recv_idle_pct = 60;
        send_item(mk_item(KIND_LOOKUP, 64'd5, 1'b1, '0, 1'b0));
        send_item(mk_item(KIND_LOOKUP, 64'd5, 1'b0, '0, 1'b1));
        send_item(mk_item(KIND_INSERT, 64'd7, 1'b0, 64'd1, 1'b1));
        send_item(mk_item(KIND_INSERT, 64'd7, 1'b1, 64'd1, 1'b0));
        send_item(mk_item(KIND_INSERT, 64'd7, 1'b0, 64'd1, 1'b0));
        send_item(mk_item(KIND_INSERT, '1, 1'b1, '1, 1'b1));
        send_item(mk_item(KIND_INSERT, '0, 1'b1, '0, 1'b1));
        send_item(mk_item(KIND_INSERT, 64'h8000_0000_0000_0000, 1'b1, 64'd1, 1'b1));
        send_item(mk_item(KIND_INSERT, 64'h7fff_ffff_ffff_ffff, 1'b1, 64'd2, 1'b1));
        send_item(mk_item(KIND_INSERT, 64'h1234, 1'b1, 64'h5a5a_a5a5_0f0f_f0f0, 1'b1));
        send_item(mk_item(KIND_LOOKUP, '0, 1'b1, '0, 1'b0));
        send_item(mk_item(KIND_LOOKUP, '1, 1'b1, '0, 1'b0));
        send_item(mk_item(KIND_LOOKUP, 64'h8000_0000_0000_0000, 1'b1, '0, 1'b0));
        send_item(mk_item(KIND_LOOKUP, 64'h1235, 1'b1, '0, 1'b0));
        send_item(mk_item(KIND_LOOKUP, 64'h7fff_ffff_ffff_fffe, 1'b1, '0, 1'b0));
        send_item(mk_item(KIND_INSERT, 64'h8000_0000_0000_0000, 1'b1, 64'd1, 1'b1));
        send_item(mk_item(KIND_INSERT, 64'h8000_0000_0000_0000, 1'b1, 64'd3, 1'b1));
        send_item(mk_item(KIND_LOOKUP, 64'h1234, 1'b0, '0, 1'b1));
        // capacity below fill: held entries still searched
        write_capacity(7'd0);
        send_item(mk_item(KIND_INSERT, 64'h55, 1'b1, 64'h55, 1'b1));
        send_item(mk_item(KIND_INSERT, '0, 1'b1, '0, 1'b1));
        send_item(mk_item(KIND_INSERT, '0, 1'b1, 64'd9, 1'b1));
        send_item(mk_item(KIND_LOOKUP, 64'h7fff_ffff_ffff_ffff, 1'b1, '0, 1'b0));
        // capacity above depth
        write_capacity(7'd127);
        send_item(mk_item(KIND_INSERT, 64'h55, 1'b1, 64'h55, 1'b1));
        write_capacity(7'd6);
        send_item(mk_item(KIND_INSERT, 64'h56, 1'b1, 64'h56, 1'b1));
        send_item(mk_item(KIND_LOOKUP, 64'h55, 1'b1, '0, 1'b0));
    endtask

    task automatic test_random_sender_idle();
        send_idle_pct = 36;
        recv_idle_pct = 60;
        run_phase(7'd20, 150);
        run_phase(7'd1, 100);
    endtask

    task automatic test_random_receiver_idle();
        send_idle_pct = 60;
        recv_idle_pct = 36;
        run_phase(7'd45, 150);
        run_phase(7'd0, 80);
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        settle();
        hold_request = 1;
        repeat (40) send_item(random_item());
    endtask

    task automatic test_random_no_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(7'd64, 250);
        run_phase(7'd127, 200);
        run_phase(7'd100, 100);
    endtask

    initial begin
        i_rst_n              = 1'b0;
        item_ch.valid        = 1'b0;
        item_ch.kind         = KIND_INSERT;
        item_ch.key          = '0;
        item_ch.key_tag_ok   = 1'b0;
        item_ch.value        = '0;
        item_ch.value_tag_ok = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.data          = '0;
        send_idle_pct        = 0;
        recv_idle_pct        = 0;
        hold_request         = 0;
        mismatch_count       = 0;
        quiet_cycles         = 0;
        table_fill           = 0;
        cap_reg              = int'(CAP_RESET);
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_sender_idle();
        test_random_receiver_idle();
        test_backpressure();
        test_random_no_idle();

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
